// ===== hdl/brm_pkg.sv =====
// Shared constants, types and Booth recoding helpers for the radix-4 multiplier.
package brm_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
    localparam int BOOTH_GROUPS  = OPERAND_WIDTH / 2;

    typedef logic [PRODUCT_WIDTH-1:0] term_t;

    // Three-bit Booth group {b(2g+1), b(2g), b(2g-1)}
    typedef enum logic [2:0] {
        BC_ZERO_POS  = 3'b000,
        BC_ONE_A     = 3'b001,
        BC_ONE_B     = 3'b010,
        BC_TWO       = 3'b011,
        BC_MINUS_TWO = 3'b100,
        BC_MINUS_A   = 3'b101,
        BC_MINUS_B   = 3'b110,
        BC_ZERO_NEG  = 3'b111
    } booth_code_t;

    function automatic term_t booth_term(input logic [OPERAND_WIDTH-1:0] mcand,
                                         input booth_code_t code);
        term_t ext;
        term_t res;
        ext = {{OPERAND_WIDTH{mcand[OPERAND_WIDTH-1]}}, mcand};
        unique case (code)
            BC_ONE_A, BC_ONE_B:     res = ext;
            BC_TWO:                 res = ext << 1;
            BC_MINUS_TWO:           res = '0 - (ext << 1);
            BC_MINUS_A, BC_MINUS_B: res = '0 - ext;
            BC_ZERO_POS, BC_ZERO_NEG: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/brm_recode.sv =====
// First stage: Booth recoding and registered partial product generation.
module brm_recode
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    input  logic signed [brm_pkg::OPERAND_WIDTH-1:0]           multiplicand,
    input  logic signed [brm_pkg::OPERAND_WIDTH-1:0]           multiplier,
    output logic                                               out_valid,
    output brm_pkg::term_t [brm_pkg::BOOTH_GROUPS-1:0]         out_terms
);

    logic [brm_pkg::OPERAND_WIDTH:0]            mplier_ext;
    brm_pkg::term_t [brm_pkg::BOOTH_GROUPS-1:0] terms_next;
    brm_pkg::term_t [brm_pkg::BOOTH_GROUPS-1:0] terms_reg;
    logic                                       valid_reg;

    // implicit zero below bit 0 for the first group
    assign mplier_ext = {multiplier, 1'b0};

    always_comb
    begin
        for (int g = 0; g < brm_pkg::BOOTH_GROUPS; g++)
        begin
            terms_next[g] = brm_pkg::booth_term(multiplicand,
                                brm_pkg::booth_code_t'(mplier_ext[2*g+2 -: 3])) << (2 * g);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_terms = terms_reg;

endmodule

// ===== hdl/brm_add_stage.sv =====
// One level of the registered adder tree: sums partial products in pairs.
module brm_add_stage
#(
    parameter int IN_COUNT = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  brm_pkg::term_t [IN_COUNT-1:0]       in_terms,
    output logic                                out_valid,
    output brm_pkg::term_t [IN_COUNT/2-1:0]     out_terms
);

    localparam int OUT_COUNT = IN_COUNT / 2;

    brm_pkg::term_t [OUT_COUNT-1:0] sum_next;
    brm_pkg::term_t [OUT_COUNT-1:0] sum_reg;
    logic                           valid_reg;

    always_comb
    begin
        for (int i = 0; i < OUT_COUNT; i++)
        begin
            sum_next[i] = in_terms[2*i] + in_terms[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_terms = sum_reg;

endmodule

// ===== hdl/booth_radix4_multiplier.sv =====
// Pipeline: recode stage + 4 adder levels from the accepting edge to the done strobe.
// Throughput: one request per cycle; busy is never raised, every stage advances each cycle.
// Each adder stage holds one 64-bit add level of the 16-term Booth partial product tree.
// Reset: rst_n clears the valid bits of all stages; data registers are not reset.
// The receiver cannot stall: product is shown for exactly one cycle with done.
module booth_radix4_multiplier
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [brm_pkg::OPERAND_WIDTH-1:0]  multiplicand,
    input  logic signed [brm_pkg::OPERAND_WIDTH-1:0]  multiplier,
    output logic                                      done,
    output logic signed [brm_pkg::PRODUCT_WIDTH-1:0]  product
);

    localparam int L0 = brm_pkg::BOOTH_GROUPS;
    localparam int L1 = L0 / 2;
    localparam int L2 = L1 / 2;
    localparam int L3 = L2 / 2;
    localparam int L4 = L3 / 2;

    logic                     accept;
    logic                     v0, v1, v2, v3, v4;
    brm_pkg::term_t [L0-1:0]  t0;
    brm_pkg::term_t [L1-1:0]  t1;
    brm_pkg::term_t [L2-1:0]  t2;
    brm_pkg::term_t [L3-1:0]  t3;
    brm_pkg::term_t [L4-1:0]  t4;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    brm_recode u_recode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (v0),
        .out_terms    (t0)
    );

    brm_add_stage #(.IN_COUNT(L0)) u_add1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0),
        .in_terms  (t0),
        .out_valid (v1),
        .out_terms (t1)
    );

    brm_add_stage #(.IN_COUNT(L1)) u_add2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_terms  (t1),
        .out_valid (v2),
        .out_terms (t2)
    );

    brm_add_stage #(.IN_COUNT(L2)) u_add3
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_terms  (t2),
        .out_valid (v3),
        .out_terms (t3)
    );

    // last level doubles as the output register
    brm_add_stage #(.IN_COUNT(L3)) u_add4
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_terms  (t3),
        .out_valid (v4),
        .out_terms (t4)
    );

    assign done    = v4;
    assign product = t4[0];

endmodule
